>>> hdl/bpe_pkg.sv
// bpe_pkg: shared widths, types and codes for the bezier point evaluator
// used by bpe_lane, bpe_merge and bezier_point_evaluator_unit; no dependencies
package bpe_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int T_FRAC_BITS = 16;
	localparam int T_WIDTH     = T_FRAC_BITS + 2;
	localparam int TU_WIDTH    = T_FRAC_BITS + 1;
	localparam int NUM_AXES    = 3;
	localparam int MAX_POINTS  = 4;
	localparam int POINT_WIDTH = NUM_AXES * COORD_WIDTH;
	localparam int COUNT_WIDTH = 3;
	localparam int BYP_WIDTH   = MAX_POINTS - 2;
	localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
	localparam int PROD_WIDTH  = DIFF_WIDTH + TU_WIDTH + 1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;
	typedef logic [TU_WIDTH-1:0]           tval_t;
	typedef logic [POINT_WIDTH-1:0]        point_t;
	typedef logic [COUNT_WIDTH-1:0]        count_t;
	typedef logic [BYP_WIDTH-1:0]          byp_t;

	// one in Q1.T_FRAC_BITS, and one half of it in the product format
	localparam tval_t T_ONE      = {1'b1, {T_FRAC_BITS{1'b0}}};
	localparam prod_t PROD_HALF  = prod_t'({1'b1, {(T_FRAC_BITS-1){1'b0}}});

	// point count codes
	localparam count_t CNT_LINEAR = 3'd2;
	localparam count_t CNT_QUAD   = 3'd3;
	localparam count_t CNT_CUBIC  = 3'd4;

	// per-stage load enables handed to every lane
	typedef struct packed {
		logic s7;
		logic s6;
		logic s5;
		logic s4;
		logic s3;
		logic s2;
	} lane_en_t;

endpackage

>>> hdl/bpe_lane.sv
// bpe_lane: one coordinate lane, three de casteljau levels as multiply and round stages
// depends on bpe_pkg
module bpe_lane (
	input  logic             clk,
	input  bpe_pkg::coord_t  pts [bpe_pkg::MAX_POINTS],
	input  bpe_pkg::tval_t   t_val,
	input  bpe_pkg::byp_t    bypass,
	input  bpe_pkg::lane_en_t en,
	output bpe_pkg::coord_t  coord
);

	// (b - a) * t, full precision
	function automatic bpe_pkg::prod_t lerp_mul(bpe_pkg::coord_t a, bpe_pkg::coord_t b,
			bpe_pkg::tval_t t);
		bpe_pkg::diff_t da;
		bpe_pkg::diff_t db;
		bpe_pkg::prod_t de;
		bpe_pkg::prod_t te;
		da = bpe_pkg::diff_t'(a);
		db = bpe_pkg::diff_t'(b);
		de = bpe_pkg::prod_t'(db) - bpe_pkg::prod_t'(da);
		te = bpe_pkg::prod_t'(t);
		return de * te;
	endfunction

	// a + round(prod / one), halves rounded up; result lies between a and b
	function automatic bpe_pkg::coord_t lerp_add(bpe_pkg::coord_t a, bpe_pkg::prod_t p);
		bpe_pkg::prod_t r;
		bpe_pkg::prod_t ae;
		r  = (p + bpe_pkg::PROD_HALF) >>> bpe_pkg::T_FRAC_BITS;
		ae = bpe_pkg::prod_t'(a);
		r  = r + ae;
		return r[bpe_pkg::COORD_WIDTH-1:0];
	endfunction

	bpe_pkg::prod_t  prod_s2 [3];
	bpe_pkg::coord_t base_s2 [3];
	bpe_pkg::tval_t  t_s2;
	logic            byp2_s2;
	bpe_pkg::coord_t q_s3 [3];
	bpe_pkg::tval_t  t_s3;
	logic            byp2_s3;
	bpe_pkg::prod_t  prod_s4 [2];
	bpe_pkg::coord_t base_s4 [2];
	bpe_pkg::tval_t  t_s4;
	bpe_pkg::coord_t q_s5 [2];
	bpe_pkg::tval_t  t_s5;
	bpe_pkg::prod_t  prod_s6;
	bpe_pkg::coord_t base_s6;
	bpe_pkg::coord_t coord_s7;

	bpe_pkg::tval_t t_lvl1;
	bpe_pkg::tval_t t_lvl2;

	// a skipped level runs with t = 0, which passes each point through unchanged
	assign t_lvl1 = bypass[0] ? '0 : t_val;
	assign t_lvl2 = byp2_s3 ? '0 : t_s3;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int k = 0; k < 3; k++) begin
				prod_s2[k] <= lerp_mul(pts[k], pts[k+1], t_lvl1);
				base_s2[k] <= pts[k];
			end
			t_s2    <= t_val;
			byp2_s2 <= bypass[1];
		end
		if (en.s3) begin
			for (int k = 0; k < 3; k++) begin
				q_s3[k] <= lerp_add(base_s2[k], prod_s2[k]);
			end
			t_s3    <= t_s2;
			byp2_s3 <= byp2_s2;
		end
		if (en.s4) begin
			for (int k = 0; k < 2; k++) begin
				prod_s4[k] <= lerp_mul(q_s3[k], q_s3[k+1], t_lvl2);
				base_s4[k] <= q_s3[k];
			end
			t_s4 <= t_s3;
		end
		if (en.s5) begin
			for (int k = 0; k < 2; k++) begin
				q_s5[k] <= lerp_add(base_s4[k], prod_s4[k]);
			end
			t_s5 <= t_s4;
		end
		if (en.s6) begin
			prod_s6 <= lerp_mul(q_s5[0], q_s5[1], t_s5);
			base_s6 <= q_s5[0];
		end
		if (en.s7) begin
			coord_s7 <= lerp_add(base_s6, prod_s6);
		end
	end

	assign coord = coord_s7;

endmodule

>>> hdl/bpe_merge.sv
// bpe_merge: packs the three lane coordinates, applies the error zeroing, output register
// depends on bpe_pkg
module bpe_merge (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            lane_vld,
	input  logic            lane_err,
	input  bpe_pkg::coord_t lane_coord [bpe_pkg::NUM_AXES],
	output logic            take,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output bpe_pkg::point_t result_point,
	output logic            error_flag
);

	logic            rsp_valid_q;
	bpe_pkg::point_t result_q;
	logic            err_q;
	bpe_pkg::point_t packed_pt;

	always_comb begin
		for (int a = 0; a < bpe_pkg::NUM_AXES; a++) begin
			packed_pt[a*bpe_pkg::COORD_WIDTH +: bpe_pkg::COORD_WIDTH] = lane_coord[a];
		end
	end

	assign take = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= lane_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (take && lane_vld) begin
			result_q <= lane_err ? '0 : packed_pt;
			err_q    <= lane_err;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign result_point = result_q;
	assign error_flag   = err_q;

endmodule

>>> hdl/bezier_point_evaluator_unit.sv
// bezier_point_evaluator_unit: top level, input stage, stage control, lanes and merge
// depends on bpe_pkg, bpe_lane, bpe_merge
//
// Evaluates a 3-D Bezier curve of 2, 3 or 4 control points at parameter t by de
// casteljau repeated interpolation, each step rounded to the Q7.8 coordinate grid.
// One query beat is taken every cycle while req_ready is high, and each query passes
// through an input register, then three interpolation levels of two stages
// each (a multiply of the point difference by t, then round and add back the base
// point), then the output register. Three identical lanes, one for x, y and z, run
// side by side; the merge stage packs them and forces the point to zero when the
// point count is outside 2..4. Linear and quadratic curves run through the same
// pipeline with the leading levels fed t = 0, so every query has the same latency.
// The request channel stalls only when the result register is held and no stage
// further down has a bubble; t is clamped to 0..1 before use.
module bezier_point_evaluator_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  bpe_pkg::point_t        point_0,
	input  bpe_pkg::point_t        point_1,
	input  bpe_pkg::point_t        point_2,
	input  bpe_pkg::point_t        point_3,
	input  bpe_pkg::count_t        point_count,
	input  logic signed [bpe_pkg::T_WIDTH-1:0] curve_param,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output bpe_pkg::point_t        result_point,
	output logic                   error_flag
);

	// stage valids and error tags, stage 1 is the input register
	logic [7:1] stg_vld_q;
	logic [7:1] stg_err_q;
	logic [8:1] stg_en;
	logic       merge_take;

	bpe_pkg::point_t pt_s1 [bpe_pkg::MAX_POINTS];
	bpe_pkg::tval_t  t_s1;
	bpe_pkg::byp_t   byp_s1;

	bpe_pkg::tval_t  t_clamp;
	bpe_pkg::byp_t   byp_in;
	logic            err_in;
	logic            req_beat;

	bpe_pkg::lane_en_t lane_en;
	bpe_pkg::coord_t   lane_coord [bpe_pkg::NUM_AXES];

	assign req_beat = req_valid && req_ready;

	// clamp t to 0..one
	always_comb begin
		if (curve_param[bpe_pkg::T_WIDTH-1]) begin
			t_clamp = '0;
		end else if (curve_param[bpe_pkg::T_WIDTH-2:0] > bpe_pkg::T_ONE) begin
			t_clamp = bpe_pkg::T_ONE;
		end else begin
			t_clamp = curve_param[bpe_pkg::T_WIDTH-2:0];
		end
	end

	// bit 0 skips level one, bit 1 skips level two
	always_comb begin
		unique case (point_count)
			bpe_pkg::CNT_LINEAR: begin
				byp_in = 2'b11;
				err_in = 1'b0;
			end
			bpe_pkg::CNT_QUAD: begin
				byp_in = 2'b01;
				err_in = 1'b0;
			end
			bpe_pkg::CNT_CUBIC: begin
				byp_in = 2'b00;
				err_in = 1'b0;
			end
			default: begin
				byp_in = 2'b11;
				err_in = 1'b1;
			end
		endcase
	end

	// a stage loads when it is empty or its content moves on this cycle
	always_comb begin
		stg_en[8] = merge_take;
		for (int k = 7; k >= 1; k--) begin
			stg_en[k] = !stg_vld_q[k] || stg_en[k+1];
		end
	end

	assign req_ready = stg_en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= '0;
		end else begin
			if (stg_en[1]) begin
				stg_vld_q[1] <= req_valid;
			end
			for (int k = 2; k <= 7; k++) begin
				if (stg_en[k]) begin
					stg_vld_q[k] <= stg_vld_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stg_en[1]) begin
			pt_s1[0]     <= point_0;
			pt_s1[1]     <= point_1;
			pt_s1[2]     <= point_2;
			pt_s1[3]     <= point_3;
			t_s1         <= t_clamp;
			byp_s1       <= byp_in;
			stg_err_q[1] <= err_in;
		end
		for (int k = 2; k <= 7; k++) begin
			if (stg_en[k]) begin
				stg_err_q[k] <= stg_err_q[k-1];
			end
		end
	end

	assign lane_en.s2 = stg_en[2];
	assign lane_en.s3 = stg_en[3];
	assign lane_en.s4 = stg_en[4];
	assign lane_en.s5 = stg_en[5];
	assign lane_en.s6 = stg_en[6];
	assign lane_en.s7 = stg_en[7];

	// one lane per axis
	for (genvar a = 0; a < bpe_pkg::NUM_AXES; a++) begin : g_lane
		bpe_pkg::coord_t lane_pts [bpe_pkg::MAX_POINTS];

		for (genvar p = 0; p < bpe_pkg::MAX_POINTS; p++) begin : g_pt
			assign lane_pts[p] = pt_s1[p][a*bpe_pkg::COORD_WIDTH +: bpe_pkg::COORD_WIDTH];
		end

		bpe_lane u_lane (
			.clk    (clk),
			.pts    (lane_pts),
			.t_val  (t_s1),
			.bypass (byp_s1),
			.en     (lane_en),
			.coord  (lane_coord[a])
		);
	end

	bpe_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.lane_vld     (stg_vld_q[7]),
		.lane_err     (stg_err_q[7]),
		.lane_coord   (lane_coord),
		.take         (merge_take),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.result_point (result_point),
		.error_flag   (error_flag)
	);

	// an error result carries a zero point
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && error_flag |-> result_point == '0)
		else $error("error beat with nonzero point");

	// a bad point count is tagged as an error in the input stage
	a_err_tag: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat && (point_count < bpe_pkg::CNT_LINEAR || point_count > bpe_pkg::CNT_CUBIC)
		|=> stg_vld_q[1] && stg_err_q[1])
		else $error("bad point count not tagged");

	// a negative t is clamped to zero
	a_t_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat && curve_param[bpe_pkg::T_WIDTH-1] |=> t_s1 == '0)
		else $error("negative t not clamped");

	// an item in the last lane stage is never dropped while the merge is blocked
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		stg_vld_q[7] && !merge_take |=> stg_vld_q[7])
		else $error("item lost at merge stall");

endmodule
